// ===== sv/tpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tpt_pkg: shared types and constants for the tag presence table
// Entry layout, table geometry, ID character codes and controller states.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SLOT_W        = 6;
  localparam int WORD_W        = 64;
  localparam int CHAR_W        = 8;
  localparam int IDLE_W        = 8;

  localparam logic [CHAR_W-1:0] CHAR_U     = 8'h55;  // 'U'
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [IDLE_W-1:0] IDLE_MAX   = 8'hFF;
  localparam logic [IDLE_W-1:0] LIMIT_RST  = 8'd20;

  localparam logic EV_ARRIVE = 1'b0;
  localparam logic EV_DEPART = 1'b1;
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w3;
    logic [CHAR_W-1:0] tail;
  } tag_id_t;

  typedef struct packed {
    logic [IDLE_W-1:0] idle;
    tag_id_t           id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic    kind;
    idx_t    slot;
    tag_id_t id;
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

// ===== sv/tpt_ram.sv =====
// ----------------------------------------------------------------------------
// tpt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tag_presence_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// tag_presence_table_with_aging: table of present tags with idle aging
// Walk: each request keeps busy high while the single RAM read port walks
//   the table one entry per cycle, through the registered read and a closing
//   FINISH state. Events appear at most one per cycle during the walk; the
//   final event of a request strobes in the same cycle that busy drops, and a
//   new request is taken only once busy is low. The receiver cannot stall results.
// Reset: synchronous active-low; table empties (valid bits cleared), idle
//   limit returns to 20, any request in flight is dropped.
// ----------------------------------------------------------------------------
module tag_presence_table_with_aging (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [tpt_pkg::WORD_W-1:0]    in_id_word0,
  input  logic [tpt_pkg::WORD_W-1:0]    in_id_word1,
  input  logic [tpt_pkg::WORD_W-1:0]    in_id_word2,
  input  logic [tpt_pkg::WORD_W-1:0]    in_id_word3,
  input  logic [tpt_pkg::CHAR_W-1:0]    in_id_tail,
  // event channel
  output logic                          out_valid,
  output logic                          out_event_kind,
  output logic [tpt_pkg::SLOT_W-1:0]    out_slot,
  output logic [tpt_pkg::WORD_W-1:0]    out_word0,
  output logic [tpt_pkg::WORD_W-1:0]    out_word1,
  output logic [tpt_pkg::WORD_W-1:0]    out_word2,
  output logic [tpt_pkg::WORD_W-1:0]    out_word3,
  output logic [tpt_pkg::CHAR_W-1:0]    out_tail,
  output logic                          out_last,
  // idle limit register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tpt_pkg::IDLE_W-1:0]    cfg_data
);

  localparam tpt_pkg::idx_t LAST_IDX = tpt_pkg::idx_t'(tpt_pkg::TABLE_ENTRIES - 1);

  // Controller
  tpt_pkg::state_t  state_r, state_nxt;
  tpt_pkg::idx_t    cnt_r, cnt_nxt;          // next entry to read
  logic             issue_done_r, issue_done_nxt;
  logic             chk_vld_r, chk_vld_nxt;  // RAM data valid this cycle
  tpt_pkg::idx_t    chk_idx_r, chk_idx_nxt;  // entry whose data is on rdata

  // Latched request
  logic             mode_r;
  tpt_pkg::tag_id_t id_r;

  // Walk results for a tag read
  logic             matched_r, matched_nxt;
  logic             free_vld_r, free_vld_nxt;
  tpt_pkg::idx_t    free_idx_r, free_idx_nxt;

  // Table presence and configuration
  logic [tpt_pkg::TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [tpt_pkg::IDLE_W-1:0]        limit_r;

  // One event held back so the last one of a request can be flagged
  logic             pend_vld_r, pend_vld_nxt;
  tpt_pkg::event_t  pend_r, pend_nxt;

  // Output register
  logic             out_vld_r, out_vld_nxt;
  tpt_pkg::event_t  out_ev_r, out_ev_nxt;
  logic             out_last_r, out_last_nxt;

  // RAM ports
  logic             ram_we, ram_re;
  tpt_pkg::idx_t    ram_waddr, ram_raddr;
  tpt_pkg::entry_t  ram_wdata, ram_rdata;

  // Entry processing terms
  logic                       cur_valid;
  logic [tpt_pkg::IDLE_W-1:0] idle_inc;
  logic                       id_hit;
  logic                       qualifies;
  logic                       accept;

  assign busy      = (state_r != tpt_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  tpt_ram #(
    .WIDTH (tpt_pkg::ENTRY_W),
    .DEPTH (tpt_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_valid = valid_r[chk_idx_r];
  assign idle_inc  = (ram_rdata.idle == tpt_pkg::IDLE_MAX) ? tpt_pkg::IDLE_MAX
                                                           : ram_rdata.idle + 8'd1;
  assign id_hit    = (ram_rdata.id == id_r);

  always_comb begin
    qualifies = (id_r.w0[tpt_pkg::WORD_W-1 -: tpt_pkg::CHAR_W] == tpt_pkg::CHAR_U) &&
                (id_r.tail inside {[tpt_pkg::CHAR_ZERO:tpt_pkg::CHAR_NINE]});
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    issue_done_nxt = issue_done_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    matched_nxt    = matched_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    pend_vld_nxt   = pend_vld_r;
    pend_nxt       = pend_r;
    out_vld_nxt    = 1'b0;
    out_ev_nxt     = out_ev_r;
    out_last_nxt   = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = chk_idx_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = cnt_r;

    case (state_r)
      tpt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt      = tpt_pkg::ST_WALK;
          cnt_nxt        = '0;
          issue_done_nxt = 1'b0;
          matched_nxt    = 1'b0;
          free_vld_nxt   = 1'b0;
          pend_vld_nxt   = 1'b0;
        end
      end

      tpt_pkg::ST_WALK: begin
        // Issue: read one entry per cycle until the whole table is out
        if (!issue_done_r) begin
          ram_re      = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = cnt_r;
          if (cnt_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end

        // Modify and write back the entry whose data just came out
        if (chk_vld_r) begin
          if (mode_r == tpt_pkg::MODE_TICK) begin
            if (cur_valid) begin
              ram_we         = 1'b1;
              ram_wdata.idle = idle_inc;
              if (idle_inc > limit_r) begin
                // Expire: free the entry, release the held event, hold this one
                ram_wdata.idle       = '0;
                valid_nxt[chk_idx_r] = 1'b0;
                if (pend_vld_r) begin
                  out_vld_nxt  = 1'b1;
                  out_ev_nxt   = pend_r;
                  out_last_nxt = 1'b0;
                end
                pend_vld_nxt  = 1'b1;
                pend_nxt.kind = tpt_pkg::EV_DEPART;
                pend_nxt.slot = chk_idx_r;
                pend_nxt.id   = ram_rdata.id;
              end
            end
          end else begin
            if (!matched_r && cur_valid && id_hit) begin
              ram_we         = 1'b1;
              ram_wdata.idle = '0;
              matched_nxt    = 1'b1;
            end
            if (!cur_valid && !free_vld_r) begin
              free_vld_nxt = 1'b1;
              free_idx_nxt = chk_idx_r;
            end
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = tpt_pkg::ST_FINISH;
          end
        end
      end

      tpt_pkg::ST_FINISH: begin
        state_nxt = tpt_pkg::ST_IDLE;
        if (mode_r == tpt_pkg::MODE_TICK) begin
          // Flush the held departure as the last event of the request
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_ev_nxt   = pend_r;
            out_last_nxt = 1'b1;
            pend_vld_nxt = 1'b0;
          end
        end else if (!matched_r && qualifies && free_vld_r) begin
          // Store the new tag in the lowest free entry and report arrival
          ram_we                = 1'b1;
          ram_waddr             = free_idx_r;
          ram_wdata.idle        = '0;
          ram_wdata.id          = id_r;
          valid_nxt[free_idx_r] = 1'b1;
          out_vld_nxt           = 1'b1;
          out_ev_nxt.kind       = tpt_pkg::EV_ARRIVE;
          out_ev_nxt.slot       = free_idx_r;
          out_ev_nxt.id         = id_r;
          out_last_nxt          = 1'b1;
        end
      end

      default: begin
        state_nxt = tpt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tpt_pkg::ST_IDLE;
      issue_done_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      matched_r    <= 1'b0;
      free_vld_r   <= 1'b0;
      valid_r      <= '0;
      limit_r      <= tpt_pkg::LIMIT_RST;
      pend_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      chk_vld_r    <= chk_vld_nxt;
      matched_r    <= matched_nxt;
      free_vld_r   <= free_vld_nxt;
      valid_r      <= valid_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  // Payload and walk indexes
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    chk_idx_r  <= chk_idx_nxt;
    free_idx_r <= free_idx_nxt;
    pend_r     <= pend_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
    if (accept) begin
      mode_r     <= in_mode;
      id_r.w0    <= in_id_word0;
      id_r.w1    <= in_id_word1;
      id_r.w2    <= in_id_word2;
      id_r.w3    <= in_id_word3;
      id_r.tail  <= in_id_tail;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_event_kind = out_ev_r.kind;
  assign out_slot       = tpt_pkg::slot_t'(out_ev_r.slot);
  assign out_word0      = out_ev_r.id.w0;
  assign out_word1      = out_ev_r.id.w1;
  assign out_word2      = out_ev_r.id.w2;
  assign out_word3      = out_ev_r.id.w3;
  assign out_tail       = out_ev_r.id.tail;
  assign out_last       = out_last_r;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tag_presence_table_with_aging
// Drives aging ticks and tag reads through the start/busy request port, keeps
// a shadow presence table to predict arrival and departure events, and checks
// every strobed event field by field. The idle limit register is rewritten
// between phases, including its extremes and the saturating value 255.
// ----------------------------------------------------------------------------
module testbench;

  // One walk over the table plus the registered read and the closing state
  localparam int WALK_CYCLES   = tpt_pkg::TABLE_ENTRIES + 2;
  // Settle time before a register write or the end of the run
  localparam int SETTLE_CYCLES = WALK_CYCLES + 4;
  // Bound on waiting for outstanding events of the last request
  localparam int DRAIN_LIMIT   = 4 * WALK_CYCLES;
  localparam int TIMEOUT       = 5_000_000;

  typedef struct {
    logic             kind;
    tpt_pkg::slot_t   slot;
    tpt_pkg::tag_id_t id;
    logic             last;
  } tag_event_t;

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          start        = 1'b0;
  logic                          busy;
  logic                          in_mode      = tpt_pkg::MODE_TICK;
  logic [tpt_pkg::WORD_W-1:0]    in_id_word0  = '0;
  logic [tpt_pkg::WORD_W-1:0]    in_id_word1  = '0;
  logic [tpt_pkg::WORD_W-1:0]    in_id_word2  = '0;
  logic [tpt_pkg::WORD_W-1:0]    in_id_word3  = '0;
  logic [tpt_pkg::CHAR_W-1:0]    in_id_tail   = '0;
  logic                          out_valid;
  logic                          out_event_kind;
  logic [tpt_pkg::SLOT_W-1:0]    out_slot;
  logic [tpt_pkg::WORD_W-1:0]    out_word0;
  logic [tpt_pkg::WORD_W-1:0]    out_word1;
  logic [tpt_pkg::WORD_W-1:0]    out_word2;
  logic [tpt_pkg::WORD_W-1:0]    out_word3;
  logic [tpt_pkg::CHAR_W-1:0]    out_tail;
  logic                          out_last;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic [tpt_pkg::IDLE_W-1:0]    cfg_data     = '0;

  // Shadow copy of the presence table and the idle limit register
  logic                          entry_present [tpt_pkg::TABLE_ENTRIES];
  tpt_pkg::tag_id_t              entry_tag     [tpt_pkg::TABLE_ENTRIES];
  logic [tpt_pkg::IDLE_W-1:0]    entry_idle_cnt[tpt_pkg::TABLE_ENTRIES];
  logic [tpt_pkg::IDLE_W-1:0]    idle_limit_q  = tpt_pkg::LIMIT_RST;

  // Events predicted but not yet seen on the event port, oldest first
  tag_event_t           expected_events[$];
  int                   fail_count   = 0;
  bit                   idling_on    = 1'b1;

  tag_presence_table_with_aging dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_id_word0    (in_id_word0),
    .in_id_word1    (in_id_word1),
    .in_id_word2    (in_id_word2),
    .in_id_word3    (in_id_word3),
    .in_id_tail     (in_id_tail),
    .out_valid      (out_valid),
    .out_event_kind (out_event_kind),
    .out_slot       (out_slot),
    .out_word0      (out_word0),
    .out_word1      (out_word1),
    .out_word2      (out_word2),
    .out_word3      (out_word3),
    .out_tail       (out_tail),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    for (int s = 0; s < tpt_pkg::TABLE_ENTRIES; s++) begin
      entry_present[s]  = 1'b0;
      entry_tag[s]      = '0;
      entry_idle_cnt[s] = '0;
    end
  end

  // Apply one accepted request to the shadow table and queue its events.
  // A tick ages every present entry and frees the expired ones in ascending
  // slot order; a read refreshes a matching entry or stores a new tag.
  task automatic presence_update(input logic mode, input tpt_pkg::tag_id_t id);
    tag_event_t batch[$];
    tag_event_t ev;
    int         hit;
    int         free_slot;
    hit       = -1;
    free_slot = -1;
    if (mode == tpt_pkg::MODE_TICK) begin
      for (int s = 0; s < tpt_pkg::TABLE_ENTRIES; s++) begin
        if (!entry_present[s]) continue;
        // hold the count at its top value instead of wrapping
        if (entry_idle_cnt[s] != tpt_pkg::IDLE_MAX) begin
          entry_idle_cnt[s] = entry_idle_cnt[s] + 1'b1;
        end
        if (entry_idle_cnt[s] > idle_limit_q) begin
          ev.kind = tpt_pkg::EV_DEPART;
          ev.slot = tpt_pkg::slot_t'(s);
          ev.id   = entry_tag[s];
          ev.last = 1'b0;
          batch.push_back(ev);
          entry_present[s]  = 1'b0;
          entry_idle_cnt[s] = '0;
        end
      end
    end else begin
      // all 33 characters take part in the match, zero bytes included
      for (int s = 0; s < tpt_pkg::TABLE_ENTRIES; s++) begin
        if (hit < 0 && entry_present[s] && entry_tag[s] == id) hit = s;
      end
      if (hit >= 0) begin
        entry_idle_cnt[hit] = '0;
      end else if (id.w0[tpt_pkg::WORD_W-1 -: tpt_pkg::CHAR_W] == tpt_pkg::CHAR_U &&
                   id.tail >= tpt_pkg::CHAR_ZERO && id.tail <= tpt_pkg::CHAR_NINE) begin
        for (int s = 0; s < tpt_pkg::TABLE_ENTRIES; s++) begin
          if (free_slot < 0 && !entry_present[s]) free_slot = s;
        end
        // a full table drops the read without an event
        if (free_slot >= 0) begin
          entry_present[free_slot]  = 1'b1;
          entry_tag[free_slot]      = id;
          entry_idle_cnt[free_slot] = '0;
          ev.kind = tpt_pkg::EV_ARRIVE;
          ev.slot = tpt_pkg::slot_t'(free_slot);
          ev.id   = id;
          ev.last = 1'b0;
          batch.push_back(ev);
        end
      end
    end
    // mark the final event of this request
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_events.push_back(batch[i]);
  endtask

  function automatic tpt_pkg::tag_id_t random_id();
    tpt_pkg::tag_id_t t;
    t.w0   = {$urandom, $urandom};
    t.w1   = {$urandom, $urandom};
    t.w2   = {$urandom, $urandom};
    t.w3   = {$urandom, $urandom};
    t.tail = tpt_pkg::CHAR_W'($urandom);
    return t;
  endfunction

  // Random tag that passes the arrival filter: leading 'U', trailing digit
  function automatic tpt_pkg::tag_id_t fresh_tag();
    tpt_pkg::tag_id_t t;
    t = random_id();
    t.w0[tpt_pkg::WORD_W-1 -: tpt_pkg::CHAR_W] = tpt_pkg::CHAR_U;
    t.tail = tpt_pkg::CHAR_W'(tpt_pkg::CHAR_ZERO + $urandom_range(0, 9));
    return t;
  endfunction

  function automatic int random_present_slot();
    int live[$];
    for (int s = 0; s < tpt_pkg::TABLE_ENTRIES; s++) begin
      if (entry_present[s]) live.push_back(s);
    end
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // Present one request and hold it until the block takes it. Start stays
  // high on return so back-to-back requests need no second assignment in
  // the same step.
  task automatic send_request(input logic mode, input tpt_pkg::tag_id_t id);
    int burst;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      // sometimes let the walk finish first so the gap lands after busy
      if ($urandom_range(0, 1) == 1) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
      burst = $urandom_range(1, 12);
      repeat (burst) @(posedge clk);
    end
    start       <= 1'b1;
    in_mode     <= mode;
    in_id_word0 <= id.w0;
    in_id_word1 <= id.w1;
    in_id_word2 <= id.w2;
    in_id_word3 <= id.w3;
    in_id_tail  <= id.tail;
    do @(posedge clk); while (busy);
    presence_update(mode, id);
  endtask

  task automatic tick();
    send_request(tpt_pkg::MODE_TICK, random_id());
  endtask

  // Drop start, wait for every predicted event, then let a walk that
  // produces nothing run out before the port is touched again.
  task automatic drain_events();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_events.size() != 0) begin
      $error("%0d expected events never arrived", expected_events.size());
      fail_count++;
      expected_events.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle_limit(input logic [tpt_pkg::IDLE_W-1:0] value);
    drain_events();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    idle_limit_q = value;
    cfg_valid <= 1'b0;
  endtask

  // Event checker: each strobe must match the oldest prediction exactly
  function automatic void check_field(input string name,
                                      input logic [tpt_pkg::WORD_W-1:0] want,
                                      input logic [tpt_pkg::WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : event_check
    tag_event_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_events.size() == 0) begin
        $error("unexpected event: kind %0d slot %0d", out_event_kind, out_slot);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", tpt_pkg::WORD_W'(want.kind),
                    tpt_pkg::WORD_W'(out_event_kind));
        check_field("slot",       tpt_pkg::WORD_W'(want.slot), tpt_pkg::WORD_W'(out_slot));
        check_field("out_word0",  want.id.w0,         out_word0);
        check_field("out_word1",  want.id.w1,         out_word1);
        check_field("out_word2",  want.id.w2,         out_word2);
        check_field("out_word3",  want.id.w3,         out_word3);
        check_field("out_tail",   tpt_pkg::WORD_W'(want.id.tail),
                    tpt_pkg::WORD_W'(out_tail));
        check_field("last",       tpt_pkg::WORD_W'(want.last), tpt_pkg::WORD_W'(out_last));
      end
    end
  end

  // Reset-value limit: arrivals, refreshes, byte-exact matching and the
  // arrival filter on both ends of the ID.
  task automatic test_basic_reads();
    tpt_pkg::tag_id_t id_low;
    tpt_pkg::tag_id_t id_high;
    tpt_pkg::tag_id_t probe;
    id_low.w0   = {tpt_pkg::CHAR_U, 56'h0};
    id_low.w1   = '0;
    id_low.w2   = '0;
    id_low.w3   = '0;
    id_low.tail = tpt_pkg::CHAR_ZERO;
    id_high.w0   = {tpt_pkg::CHAR_U, {(tpt_pkg::WORD_W-tpt_pkg::CHAR_W){1'b1}}};
    id_high.w1   = '1;
    id_high.w2   = '1;
    id_high.w3   = '1;
    id_high.tail = tpt_pkg::CHAR_NINE;
    tick();                                     // empty table: nothing departs
    send_request(tpt_pkg::MODE_READ, id_low);   // arrival in the lowest slot
    send_request(tpt_pkg::MODE_READ, id_high);
    send_request(tpt_pkg::MODE_READ, id_low);   // refresh, no event
    probe = id_low;
    probe.tail = tpt_pkg::CHAR_ZERO + 8'd1;     // differs only in the last character
    send_request(tpt_pkg::MODE_READ, probe);
    probe = id_low;
    probe.w3 = 64'h1;                           // differs in a zero byte mid-ID
    send_request(tpt_pkg::MODE_READ, probe);
    probe = id_low;
    probe.tail = tpt_pkg::CHAR_NINE + 8'd1;     // just above '9'
    send_request(tpt_pkg::MODE_READ, probe);
    probe.tail = tpt_pkg::CHAR_ZERO - 8'd1;     // just below '0'
    send_request(tpt_pkg::MODE_READ, probe);
    probe = id_low;
    probe.w0[tpt_pkg::WORD_W-1 -: tpt_pkg::CHAR_W] = tpt_pkg::CHAR_U - 8'd1;
    probe.tail = tpt_pkg::CHAR_ZERO + 8'd5;     // wrong leading character
    send_request(tpt_pkg::MODE_READ, probe);
    send_request(tpt_pkg::MODE_READ, '0);
    send_request(tpt_pkg::MODE_READ, '1);
    send_request(tpt_pkg::MODE_READ, id_high);  // refresh
    tick();
  endtask

  // Small limits: bulk departures in one tick, empty ticks, refresh timing
  task automatic test_departures();
    tpt_pkg::tag_id_t tag_a;
    tpt_pkg::tag_id_t tag_b;
    tag_a = fresh_tag();
    tag_b = fresh_tag();
    set_idle_limit(8'd0);
    send_request(tpt_pkg::MODE_READ, tag_a);
    send_request(tpt_pkg::MODE_READ, tag_b);
    tick();                                     // every present entry departs
    tick();
    set_idle_limit(8'd1);
    send_request(tpt_pkg::MODE_READ, tag_a);
    tick();
    send_request(tpt_pkg::MODE_READ, tag_a);    // refresh resets the idle count
    send_request(tpt_pkg::MODE_READ, tag_b);
    tick();
    tick();
  endtask

  // Fill every slot, overflow with a dropped read, then expire the whole
  // table in a single tick.
  task automatic test_full_table();
    int s;
    set_idle_limit(8'd254);
    for (int n = 0; n < tpt_pkg::TABLE_ENTRIES + 1; n++) begin
      send_request(tpt_pkg::MODE_READ, fresh_tag());
    end
    s = random_present_slot();
    if (s >= 0) send_request(tpt_pkg::MODE_READ, entry_tag[s]);
    set_idle_limit(8'd0);
    tick();
  endtask

  // Limit 255 is never exceeded by the saturating count, so an idle tag stays; a limit of 0
  // then releases it on the next tick.
  task automatic test_idle_limit_top();
    set_idle_limit(8'd255);
    send_request(tpt_pkg::MODE_READ, fresh_tag());
    repeat (3) tick();
    set_idle_limit(8'd0);
    tick();
  endtask

  // Mostly well-formed traffic over several limits; noise reads are extra
  task automatic test_random_traffic();
    int               counted;
    int               s;
    int               pick;
    tpt_pkg::tag_id_t t;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_idle_limit(tpt_pkg::IDLE_W'($urandom_range(0, 3)));
        1: set_idle_limit(tpt_pkg::IDLE_W'($urandom_range(2, 8)));
        2: set_idle_limit(tpt_pkg::IDLE_W'($urandom_range(0, 254)));
        default: set_idle_limit(tpt_pkg::IDLE_W'($urandom_range(0, 5)));
      endcase
      // last phase runs flat out
      idling_on = (phase != 3);
      counted = 0;
      while (counted < 4) begin
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
          tick();
          counted++;
        end else if (pick <= 8) begin
          s = random_present_slot();
          if (pick >= 7 && s >= 0) send_request(tpt_pkg::MODE_READ, entry_tag[s]);
          else send_request(tpt_pkg::MODE_READ, fresh_tag());
          counted++;
        end else begin
          // noise: bad leading character, bad tail, or a near miss
          t = fresh_tag();
          case ($urandom_range(0, 2))
            0: begin
              t.w0[tpt_pkg::WORD_W-1 -: tpt_pkg::CHAR_W] = tpt_pkg::CHAR_W'($urandom);
              if (t.w0[tpt_pkg::WORD_W-1 -: tpt_pkg::CHAR_W] == tpt_pkg::CHAR_U) begin
                t.w0[tpt_pkg::WORD_W-1 -: tpt_pkg::CHAR_W] = tpt_pkg::CHAR_U ^ 8'h01;
              end
            end
            1: begin
              t.tail = ($urandom_range(0, 1) == 0)
                       ? tpt_pkg::CHAR_W'($urandom_range(0, 47))
                       : tpt_pkg::CHAR_W'($urandom_range(58, 255));
            end
            default: begin
              s = random_present_slot();
              if (s >= 0) t = entry_tag[s];
              t = t ^ (tpt_pkg::tag_id_t'(1) <<
                       $urandom_range(0, $bits(tpt_pkg::tag_id_t) - 1));
            end
          endcase
          send_request(tpt_pkg::MODE_READ, t);
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_reads();
    test_departures();
    test_full_table();
    test_idle_limit_top();
    test_random_traffic();
    drain_events();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("TB_ERROR");
    $finish;
  end

endmodule
